// ===== sv/cholesky_factorization_engine_macros.svh =====
// Assertion macros shared by the Cholesky engine RTL.
`ifndef CHOLESKY_FACTORIZATION_ENGINE_MACROS_SVH
`define CHOLESKY_FACTORIZATION_ENGINE_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define CFE_ASSERT_IMP(LBL, CLK, RSTN, ANT, CON, MSG) \
  LBL: assert property (@(posedge CLK) disable iff (!RSTN) (ANT) |-> (CON)) else $error(MSG);

// Next-cycle implication, disabled while in reset.
`define CFE_ASSERT_NXT(LBL, CLK, RSTN, ANT, CON, MSG) \
  LBL: assert property (@(posedge CLK) disable iff (!RSTN) (ANT) |=> (CON)) else $error(MSG);

`endif

// ===== sv/cfe_pkg.sv =====
// Package of the Cholesky engine: widths, codes, command and status types.
`default_nettype none
package cfe_pkg;

  localparam int MAX_N_DEF     = 64;
  localparam int FRAC_BITS_DEF = 16;

  localparam int DATA_W = 32;
  localparam int ACC_W  = 64;
  localparam int POS_W  = 6;
  localparam int CFG_W  = 7;
  localparam int OP_W   = 2;
  localparam int STEP_W = 7;

  localparam logic [CFG_W-1:0]  CFG_RESET  = 7'd64;
  localparam logic [STEP_W-1:0] SQRT_STEPS = 7'd32;
  localparam logic [STEP_W-1:0] DIV_STEPS  = 7'd64;

  localparam logic [DATA_W-1:0] SAT32_MAX = 32'h7FFF_FFFF;
  localparam logic [DATA_W-1:0] SAT32_MIN = 32'h8000_0000;
  localparam logic [ACC_W-1:0]  SAT64_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [ACC_W-1:0]  SAT64_MIN = 64'h8000_0000_0000_0000;

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR  = 2'd0,
    OP_WRITE  = 2'd1,
    OP_FACTOR = 2'd2,
    OP_READ   = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_WRITE, S_RD_ADDR, S_RD_OUT, S_COL, S_ZERO, S_INIT,
    S_LOAD, S_RDK, S_MUL, S_SUB, S_FIN, S_UNIT, S_STORE, S_DONE
  } state_t;

  // write data source
  typedef enum logic [1:0] {WD_ZERO, WD_INPUT, WD_ROOT, WD_QUOT} wd_sel_t;
  // write address source
  typedef enum logic [1:0] {WA_CLR, WA_INPUT, WA_IJ} wa_sel_t;
  // read port A address source
  typedef enum logic [1:0] {RA_INPUT, RA_IJ, RA_IK} ra_sel_t;

  typedef struct packed {
    logic    load_in;
    logic    we;
    wd_sel_t wd_sel;
    wa_sel_t wa_sel;
    ra_sel_t ra_sel;
    logic    acc_load;
    logic    mul_en;
    logic    acc_sub;
    logic    sqrt_start;
    logic    div_start;
    logic    piv_load;
    logic    set_ok;
    logic    set_fail;
    logic    out_load_read;
    logic    out_load_factor;
  } cmd_t;

  typedef struct packed {
    logic acc_nonpos;
    logic unit_busy;
    logic out_free;
  } sts_t;

endpackage
`default_nettype wire

// ===== sv/cfe_ram.sv =====
// Generic RAM: one write port, two registered read ports.
`default_nettype none
module cfe_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic      [WIDTH-1:0]         rdata_a,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic      [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_a_r;
  logic [WIDTH-1:0] rdata_b_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_a_r <= mem_r[raddr_a];
    rdata_b_r <= mem_r[raddr_b];
  end

  assign rdata_a = rdata_a_r;
  assign rdata_b = rdata_b_r;

endmodule
`default_nettype wire

// ===== sv/cfe_ctrl.sv =====
// Controller: item decode, clearing sweep and the column/row/k sequencer.
`default_nettype none
module cfe_ctrl #(
  parameter int MAX_N = cfe_pkg::MAX_N_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  input  wire cfe_pkg::op_t                      in_op,
  output logic                                   in_ready,
  input  wire logic                              cfg_valid,
  input  wire logic [cfe_pkg::CFG_W-1:0]         cfg_data,
  input  wire cfe_pkg::sts_t                     sts,
  output cfe_pkg::cmd_t                          cmd,
  output logic [$clog2(MAX_N+1)-1:0]             idx_i,
  output logic [$clog2(MAX_N+1)-1:0]             idx_j,
  output logic [$clog2(MAX_N)-1:0]               idx_k,
  output logic [2*$clog2(MAX_N)-1:0]             clr_addr
);

  localparam int IW = $clog2(MAX_N);
  localparam int NW = $clog2(MAX_N + 1);
  localparam int AW = 2 * IW;
  localparam logic [AW-1:0] CLR_LAST = '1;

  cfe_pkg::state_t state_r, state_nxt;
  logic [NW-1:0] i_r, i_nxt, j_r, j_nxt, n;
  logic [IW-1:0] k_r, k_nxt;
  logic [AW-1:0] clr_r, clr_nxt;
  logic [cfe_pkg::CFG_W-1:0] size_r;

  // matrix order in use, clamped to 1..MAX_N
  always_comb begin
    priority if (size_r == '0) begin
      n = NW'(1);
    end else if (32'(size_r) > MAX_N) begin
      n = NW'(MAX_N);
    end else begin
      n = NW'(size_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= cfe_pkg::S_CLEAR;
      i_r     <= '0;
      j_r     <= '0;
      k_r     <= '0;
      clr_r   <= '0;
      size_r  <= cfe_pkg::CFG_RESET;
    end else begin
      state_r <= state_nxt;
      i_r     <= i_nxt;
      j_r     <= j_nxt;
      k_r     <= k_nxt;
      clr_r   <= clr_nxt;
      if (cfg_valid) begin
        size_r <= cfg_data;
      end
    end
  end

  // next state and counters
  always_comb begin
    state_nxt = state_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    k_nxt     = k_r;
    clr_nxt   = clr_r;
    unique case (state_r)
      cfe_pkg::S_CLEAR: begin
        clr_nxt = clr_r + AW'(1);
        if (clr_r == CLR_LAST) state_nxt = cfe_pkg::S_IDLE;
      end
      cfe_pkg::S_IDLE: begin
        if (in_valid) begin
          unique case (in_op)
            cfe_pkg::OP_CLEAR:  state_nxt = cfe_pkg::S_CLEAR;
            cfe_pkg::OP_WRITE:  state_nxt = cfe_pkg::S_WRITE;
            cfe_pkg::OP_FACTOR: begin
              j_nxt     = '0;
              state_nxt = cfe_pkg::S_COL;
            end
            cfe_pkg::OP_READ:   state_nxt = cfe_pkg::S_RD_ADDR;
          endcase
        end
      end
      cfe_pkg::S_WRITE:   state_nxt = cfe_pkg::S_IDLE;
      cfe_pkg::S_RD_ADDR: state_nxt = cfe_pkg::S_RD_OUT;
      cfe_pkg::S_RD_OUT: begin
        if (sts.out_free) state_nxt = cfe_pkg::S_IDLE;
      end
      cfe_pkg::S_COL: begin
        if (j_r == n) begin
          state_nxt = cfe_pkg::S_DONE;
        end else begin
          i_nxt     = '0;
          state_nxt = (j_r == '0) ? cfe_pkg::S_INIT : cfe_pkg::S_ZERO;
        end
      end
      cfe_pkg::S_ZERO: begin
        i_nxt = i_r + NW'(1);
        if ((i_r + NW'(1)) == j_r) state_nxt = cfe_pkg::S_INIT;
      end
      cfe_pkg::S_INIT: state_nxt = cfe_pkg::S_LOAD;
      cfe_pkg::S_LOAD: begin
        k_nxt     = '0;
        state_nxt = (j_r == '0) ? cfe_pkg::S_FIN : cfe_pkg::S_RDK;
      end
      cfe_pkg::S_RDK: state_nxt = cfe_pkg::S_MUL;
      cfe_pkg::S_MUL: state_nxt = cfe_pkg::S_SUB;
      cfe_pkg::S_SUB: begin
        k_nxt = k_r + IW'(1);
        state_nxt = ((NW'(k_r) + NW'(1)) == j_r) ? cfe_pkg::S_FIN : cfe_pkg::S_RDK;
      end
      cfe_pkg::S_FIN: begin
        if ((i_r == j_r) && sts.acc_nonpos) state_nxt = cfe_pkg::S_DONE;
        else state_nxt = cfe_pkg::S_UNIT;
      end
      cfe_pkg::S_UNIT: begin
        if (!sts.unit_busy) state_nxt = cfe_pkg::S_STORE;
      end
      cfe_pkg::S_STORE: begin
        i_nxt = i_r + NW'(1);
        if ((i_r + NW'(1)) == n) begin
          j_nxt     = j_r + NW'(1);
          state_nxt = cfe_pkg::S_COL;
        end else begin
          state_nxt = cfe_pkg::S_INIT;
        end
      end
      cfe_pkg::S_DONE: begin
        if (sts.out_free) state_nxt = cfe_pkg::S_IDLE;
      end
      default: state_nxt = cfe_pkg::S_IDLE;
    endcase
  end

  // commands to the datapath
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      cfe_pkg::S_CLEAR: begin
        cmd.we     = 1'b1;
        cmd.wa_sel = cfe_pkg::WA_CLR;
        cmd.wd_sel = cfe_pkg::WD_ZERO;
      end
      cfe_pkg::S_IDLE: begin
        in_ready    = 1'b1;
        cmd.load_in = in_valid;
      end
      cfe_pkg::S_WRITE: begin
        cmd.we     = 1'b1;
        cmd.wa_sel = cfe_pkg::WA_INPUT;
        cmd.wd_sel = cfe_pkg::WD_INPUT;
      end
      cfe_pkg::S_RD_ADDR: cmd.ra_sel = cfe_pkg::RA_INPUT;
      cfe_pkg::S_RD_OUT: begin
        cmd.ra_sel        = cfe_pkg::RA_INPUT;
        cmd.out_load_read = sts.out_free;
      end
      cfe_pkg::S_COL: cmd.set_ok = (j_r == n);
      cfe_pkg::S_ZERO: begin
        cmd.we     = 1'b1;
        cmd.wa_sel = cfe_pkg::WA_IJ;
        cmd.wd_sel = cfe_pkg::WD_ZERO;
      end
      cfe_pkg::S_INIT: cmd.ra_sel   = cfe_pkg::RA_IJ;
      cfe_pkg::S_LOAD: cmd.acc_load = 1'b1;
      cfe_pkg::S_RDK:  cmd.ra_sel   = cfe_pkg::RA_IK;
      cfe_pkg::S_MUL:  cmd.mul_en   = 1'b1;
      cfe_pkg::S_SUB:  cmd.acc_sub  = 1'b1;
      cfe_pkg::S_FIN: begin
        if (i_r == j_r) begin
          cmd.set_fail   = sts.acc_nonpos;
          cmd.sqrt_start = !sts.acc_nonpos;
        end else begin
          cmd.div_start = 1'b1;
        end
      end
      cfe_pkg::S_UNIT: cmd.we = 1'b0;
      cfe_pkg::S_STORE: begin
        cmd.we       = 1'b1;
        cmd.wa_sel   = cfe_pkg::WA_IJ;
        cmd.wd_sel   = (i_r == j_r) ? cfe_pkg::WD_ROOT : cfe_pkg::WD_QUOT;
        cmd.piv_load = (i_r == j_r);
      end
      cfe_pkg::S_DONE: cmd.out_load_factor = sts.out_free;
      default: cmd = '0;
    endcase
  end

  assign idx_i    = i_r;
  assign idx_j    = j_r;
  assign idx_k    = k_r;
  assign clr_addr = clr_r;

endmodule
`default_nettype wire

// ===== sv/cfe_dp.sv =====
// Datapath: matrix store, accumulator, multiplier, iterative root/divide unit, output.
`default_nettype none
module cfe_dp #(
  parameter int MAX_N     = cfe_pkg::MAX_N_DEF,
  parameter int FRAC_BITS = cfe_pkg::FRAC_BITS_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic [cfe_pkg::POS_W-1:0]          in_row,
  input  wire logic [cfe_pkg::POS_W-1:0]          in_col,
  input  wire logic [cfe_pkg::DATA_W-1:0]         in_value,
  input  wire cfe_pkg::cmd_t                      cmd,
  input  wire logic [$clog2(MAX_N+1)-1:0]         idx_i,
  input  wire logic [$clog2(MAX_N+1)-1:0]         idx_j,
  input  wire logic [$clog2(MAX_N)-1:0]           idx_k,
  input  wire logic [2*$clog2(MAX_N)-1:0]         clr_addr,
  output cfe_pkg::sts_t                           sts,
  input  wire logic                               out_ready,
  output logic                                    out_valid,
  output logic [cfe_pkg::DATA_W-1:0]              out_value,
  output logic                                    out_status,
  output logic [cfe_pkg::POS_W-1:0]               out_fail
);

  localparam int IW = $clog2(MAX_N);
  localparam int AW = 2 * IW;
  localparam int DW = cfe_pkg::DATA_W;
  localparam int CW = cfe_pkg::ACC_W;
  localparam int RW = DW + 3;

  // captured input item
  logic [IW-1:0] row_r, col_r;
  logic [DW-1:0] val_r;
  logic          oor_r;

  logic [AW-1:0] waddr, raddr_a, raddr_b;
  logic [DW-1:0] wdata, rdata_a, rdata_b;
  logic          ram_we;

  logic signed [CW-1:0] acc_r, prod_r;
  logic signed [CW:0]   diff;
  logic [DW-1:0]        piv_r;

  // iterative unit
  logic [cfe_pkg::STEP_W-1:0] cnt_r;
  logic                       sqrt_mode_r, neg_r;
  logic [CW-1:0]              work_r;
  logic [RW-1:0]              rem_r, rem_sq, trial_sq, rem_dv, piv_ext;
  logic [DW-1:0]              root_r, root_sat, quot_sat;
  logic                       qneg_ovf, qpos_ovf;

  logic                       status_r;
  logic [cfe_pkg::POS_W-1:0]  fail_r;
  logic                       out_valid_r, out_status_r;
  logic [DW-1:0]              out_value_r;
  logic [cfe_pkg::POS_W-1:0]  out_fail_r;

  // input capture
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      row_r <= IW'(in_row);
      col_r <= IW'(in_col);
      val_r <= in_value;
      oor_r <= (32'(in_row) >= MAX_N) || (32'(in_col) >= MAX_N);
    end
  end

  // store addressing and write data
  always_comb begin
    unique case (cmd.wa_sel)
      cfe_pkg::WA_CLR:   waddr = clr_addr;
      cfe_pkg::WA_INPUT: waddr = {row_r, col_r};
      default:           waddr = {idx_i[IW-1:0], idx_j[IW-1:0]};
    endcase
    unique case (cmd.wd_sel)
      cfe_pkg::WD_ZERO:  wdata = '0;
      cfe_pkg::WD_INPUT: wdata = val_r;
      cfe_pkg::WD_ROOT:  wdata = root_sat;
      default:           wdata = quot_sat;
    endcase
    unique case (cmd.ra_sel)
      cfe_pkg::RA_INPUT: raddr_a = {row_r, col_r};
      cfe_pkg::RA_IJ:    raddr_a = {idx_i[IW-1:0], idx_j[IW-1:0]};
      default:           raddr_a = {idx_i[IW-1:0], idx_k};
    endcase
    raddr_b = {idx_j[IW-1:0], idx_k};
    ram_we  = cmd.we && !((cmd.wa_sel == cfe_pkg::WA_INPUT) && oor_r);
  end

  cfe_ram #(
    .WIDTH(DW),
    .DEPTH(1 << AW)
  ) u_store (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (waddr),
    .wdata   (wdata),
    .raddr_a (raddr_a),
    .rdata_a (rdata_a),
    .raddr_b (raddr_b),
    .rdata_b (rdata_b)
  );

  // saturating accumulate
  assign diff = {acc_r[CW-1], acc_r} - {prod_r[CW-1], prod_r};

  always_ff @(posedge clk) begin
    if (cmd.acc_load) begin
      acc_r <= $signed({{(CW-DW){rdata_a[DW-1]}}, rdata_a}) <<< FRAC_BITS;
    end else if (cmd.acc_sub) begin
      priority if (diff[CW] == diff[CW-1]) acc_r <= diff[CW-1:0];
      else if (diff[CW]) acc_r <= cfe_pkg::SAT64_MIN;
      else acc_r <= cfe_pkg::SAT64_MAX;
    end
    if (cmd.mul_en) begin
      prod_r <= $signed(rdata_a) * $signed(rdata_b);
    end
    if (cmd.piv_load) begin
      piv_r <= root_sat;
    end
  end

  // square root: two radicand bits a step
  assign rem_sq   = {rem_r[DW:0], work_r[CW-1 -: 2]};
  assign trial_sq = {1'b0, root_r, 2'b01};
  // restoring division: one dividend bit a step
  assign rem_dv   = {rem_r[DW+1:0], work_r[CW-1]};
  assign piv_ext  = {3'b000, piv_r};

  assign root_sat = root_r[DW-1] ? cfe_pkg::SAT32_MAX : root_r;
  assign qneg_ovf = (|work_r[CW-1:DW]) || (work_r[DW-1] && (|work_r[DW-2:0]));
  assign qpos_ovf = |work_r[CW-1:DW-1];
  always_comb begin
    if (neg_r) quot_sat = qneg_ovf ? cfe_pkg::SAT32_MIN : (~work_r[DW-1:0] + 32'd1);
    else       quot_sat = qpos_ovf ? cfe_pkg::SAT32_MAX : work_r[DW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.sqrt_start) begin
      cnt_r <= cfe_pkg::SQRT_STEPS;
    end else if (cmd.div_start) begin
      cnt_r <= cfe_pkg::DIV_STEPS;
    end else if (cnt_r != '0) begin
      cnt_r <= cnt_r - cfe_pkg::STEP_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sqrt_start) begin
      work_r      <= acc_r;
      rem_r       <= '0;
      root_r      <= '0;
      sqrt_mode_r <= 1'b1;
    end else if (cmd.div_start) begin
      work_r      <= acc_r[CW-1] ? (~acc_r + 64'd1) : acc_r;
      neg_r       <= acc_r[CW-1];
      rem_r       <= '0;
      sqrt_mode_r <= 1'b0;
    end else if (cnt_r != '0) begin
      if (sqrt_mode_r) begin
        work_r <= {work_r[CW-3:0], 2'b00};
        if (rem_sq >= trial_sq) begin
          rem_r  <= rem_sq - trial_sq;
          root_r <= {root_r[DW-2:0], 1'b1};
        end else begin
          rem_r  <= rem_sq;
          root_r <= {root_r[DW-2:0], 1'b0};
        end
      end else begin
        if (rem_dv >= piv_ext) begin
          rem_r  <= rem_dv - piv_ext;
          work_r <= {work_r[CW-2:0], 1'b1};
        end else begin
          rem_r  <= rem_dv;
          work_r <= {work_r[CW-2:0], 1'b0};
        end
      end
    end
  end

  // factor outcome
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      status_r <= 1'b0;
      fail_r   <= '0;
    end else if (cmd.set_ok) begin
      status_r <= 1'b0;
      fail_r   <= '0;
    end else if (cmd.set_fail) begin
      status_r <= 1'b1;
      fail_r   <= cfe_pkg::POS_W'(idx_j);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load_read || cmd.out_load_factor) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load_read || cmd.out_load_factor) begin
      out_value_r  <= (cmd.out_load_read && !oor_r) ? rdata_a : '0;
      out_status_r <= status_r;
      out_fail_r   <= fail_r;
    end
  end

  assign sts.acc_nonpos = acc_r[CW-1] || (acc_r == '0);
  assign sts.unit_busy  = (cnt_r != '0);
  assign sts.out_free   = !out_valid_r || out_ready;

  assign out_valid  = out_valid_r;
  assign out_value  = out_value_r;
  assign out_status = out_status_r;
  assign out_fail   = out_fail_r;

endmodule
`default_nettype wire

// ===== sv/cholesky_factorization_engine.sv =====
// Top level of the Cholesky factorization engine.
//
// Input channel in_*: tuser carries the operation (clear, write, factor, read),
// tdata the entry position and value. Result channel out_*: one item for each
// factor or read item, none for clear or write. cfg_* writes the matrix order
// (always ready; write it only while the block is idle).
// Steps for each operation, from the accepting edge:
//   write: capture, then store write.
//   read:  capture, store read, output register load; then the next item.
//   clear: all 4^ceil(log2 MAX_N) store entries (4096 at MAX_N 64), one store entry a cycle.
//   factor: per column j, j zeroing writes, then for each row i >= j a
//     multiply-accumulate over k < j and then a square root (diagonal) or a
//     divide (below it) in the shared iterative unit.
// After reset the same clearing sweep as a clear item runs and in_tready
// stays low until it ends.
// The result sits in an output register; while the receiver stalls, write and
// clear items are still taken, and a read or factor waits for the register.
`default_nettype none
`include "cholesky_factorization_engine_macros.svh"
module cholesky_factorization_engine #(
  parameter int MAX_N     = cfe_pkg::MAX_N_DEF,
  parameter int FRAC_BITS = cfe_pkg::FRAC_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [47:0] in_tdata,   // row[5:0], col[11:6], value[43:12]
  input  wire logic [1:0]  in_tuser,   // operation[1:0]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [39:0]      out_tdata,  // result_value[31:0], fail_column[37:32]
  output logic             out_tuser,  // status[0]
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [6:0]  cfg_data    // matrix_size[6:0]
);

  localparam int IW = $clog2(MAX_N);
  localparam int NW = $clog2(MAX_N + 1);

  cfe_pkg::cmd_t cmd;
  cfe_pkg::sts_t sts;
  logic [NW-1:0] idx_i, idx_j;
  logic [IW-1:0] idx_k;
  logic [2*IW-1:0] clr_addr;
  logic [cfe_pkg::DATA_W-1:0] out_value;
  logic [cfe_pkg::POS_W-1:0]  out_fail;

  assign cfg_ready = 1'b1;

  cfe_ctrl #(
    .MAX_N(MAX_N)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_op     (cfe_pkg::op_t'(in_tuser)),
    .in_ready  (in_tready),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .sts       (sts),
    .cmd       (cmd),
    .idx_i     (idx_i),
    .idx_j     (idx_j),
    .idx_k     (idx_k),
    .clr_addr  (clr_addr)
  );

  cfe_dp #(
    .MAX_N     (MAX_N),
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_row     (in_tdata[5:0]),
    .in_col     (in_tdata[11:6]),
    .in_value   (in_tdata[43:12]),
    .cmd        (cmd),
    .idx_i      (idx_i),
    .idx_j      (idx_j),
    .idx_k      (idx_k),
    .clr_addr   (clr_addr),
    .sts        (sts),
    .out_ready  (out_tready),
    .out_valid  (out_tvalid),
    .out_value  (out_value),
    .out_status (out_tuser),
    .out_fail   (out_fail)
  );

  assign out_tdata = {2'b00, out_fail, out_value};

  // store is never written while an item can be taken
  `CFE_ASSERT_IMP(a_idle_no_write, clk, rst_n, in_tready, !cmd.we, "store write while idle")
  // root/divide unit only started when free
  `CFE_ASSERT_IMP(a_unit_free, clk, rst_n, cmd.sqrt_start || cmd.div_start, !sts.unit_busy, "unit restarted while busy")
  // a start always makes the unit busy next cycle
  `CFE_ASSERT_NXT(a_unit_runs, clk, rst_n, cmd.sqrt_start || cmd.div_start, sts.unit_busy, "unit did not start")
  // a result is loaded only into a free output register
  `CFE_ASSERT_IMP(a_out_free, clk, rst_n, cmd.out_load_read || cmd.out_load_factor, sts.out_free, "result overwritten")

endmodule
`default_nettype wire
